@@ hdl/oect_pkg.sv @@
package oect_pkg;

  localparam int NUM_VALUES_DEF = 256;
  localparam int MODE_W         = 2;
  localparam int VALUE_W        = 8;
  localparam int CLASS_W        = 8;
  localparam int OUT_W          = CLASS_W + 1;
  localparam int COUNT_W        = 9;
  localparam int MAX_IDS        = 2 ** VALUE_W;

  localparam logic [MODE_W-1:0] MODE_ADD   = 2'd0;
  localparam logic [MODE_W-1:0] MODE_MERGE = 2'd1;

  typedef struct packed {
    logic accept;
    logic look;
    logic sweep;
    logic drain;
    logic finish;
  } ctrl_cmd_t;

  typedef struct packed {
    logic need_sweep;
    logic sweep_last;
  } dp_sts_t;

endpackage

@@ hdl/ordered_equivalence_class_table.sv @@
// Add, query and merges that change nothing: LOOK raises finish and done_o is registered from it.
// A merge that joins two classes sweeps the label store one entry per cycle:
// the sweep covers D = min(NUM_VALUES, 256) entries, then DRAIN raises finish and done_o is registered from it.
// A new request is taken in the cycle that done_o is high; results cannot be stalled.
// Reset clears the present flags and the class count at once; no clearing pass.
module ordered_equivalence_class_table #(
  parameter int NUM_VALUES = oect_pkg::NUM_VALUES_DEF
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               start,
  output logic                               busy,
  input  logic [oect_pkg::MODE_W-1:0]        mode_i,
  input  logic [oect_pkg::VALUE_W-1:0]       value_a_i,
  input  logic [oect_pkg::VALUE_W-1:0]       value_b_i,
  output logic                               done_o,
  output logic signed [oect_pkg::OUT_W-1:0]  class_a_o,
  output logic signed [oect_pkg::OUT_W-1:0]  class_b_o,
  output logic [oect_pkg::COUNT_W-1:0]       class_count_o,
  output logic                               error_o
);
  import oect_pkg::*;

  ctrl_cmd_t cmd;
  dp_sts_t   sts;

  oect_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .busy   (busy),
    .sts_i  (sts),
    .cmd_o  (cmd)
  );

  oect_dp #(
    .NUM_VALUES (NUM_VALUES)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .mode_i        (mode_i),
    .value_a_i     (value_a_i),
    .value_b_i     (value_b_i),
    .done_o        (done_o),
    .class_a_o     (class_a_o),
    .class_b_o     (class_b_o),
    .class_count_o (class_count_o),
    .error_o       (error_o)
  );

endmodule

@@ hdl/oect_ctrl.sv @@
module oect_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start,
  output logic                 busy,
  input  oect_pkg::dp_sts_t    sts_i,
  output oect_pkg::ctrl_cmd_t  cmd_o
);
  import oect_pkg::*;

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_LOOK  = 2'd1;
  localparam logic [1:0] ST_SWEEP = 2'd2;
  localparam logic [1:0] ST_DRAIN = 2'd3;

  logic [1:0] state_q, state_d;

  always_comb begin
    state_d      = state_q;
    cmd_o        = '0;
    case (state_q)
      ST_IDLE: begin
        if (start) begin
          cmd_o.accept = 1'b1;
          state_d      = ST_LOOK;
        end
      end
      ST_LOOK: begin
        cmd_o.look = 1'b1;
        if (sts_i.need_sweep) begin
          state_d = ST_SWEEP;
        end else begin
          cmd_o.finish = 1'b1;
          state_d      = ST_IDLE;
        end
      end
      ST_SWEEP: begin
        cmd_o.sweep = 1'b1;
        if (sts_i.sweep_last) begin
          state_d = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        cmd_o.drain  = 1'b1;
        cmd_o.finish = 1'b1;
        state_d      = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign busy = (state_q != ST_IDLE);

endmodule

@@ hdl/oect_dp.sv @@
module oect_dp #(
  parameter int NUM_VALUES = oect_pkg::NUM_VALUES_DEF
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  oect_pkg::ctrl_cmd_t                cmd_i,
  output oect_pkg::dp_sts_t                  sts_o,
  input  logic [oect_pkg::MODE_W-1:0]        mode_i,
  input  logic [oect_pkg::VALUE_W-1:0]       value_a_i,
  input  logic [oect_pkg::VALUE_W-1:0]       value_b_i,
  output logic                               done_o,
  output logic signed [oect_pkg::OUT_W-1:0]  class_a_o,
  output logic signed [oect_pkg::OUT_W-1:0]  class_b_o,
  output logic [oect_pkg::COUNT_W-1:0]       class_count_o,
  output logic                               error_o
);
  import oect_pkg::*;

  localparam int DEPTH = (NUM_VALUES < MAX_IDS) ? NUM_VALUES : MAX_IDS;
  localparam int AW    = $clog2(DEPTH);
  localparam logic [VALUE_W:0] DepthW   = DEPTH[VALUE_W:0];
  localparam logic [AW-1:0]    LastAddr = AW'(DEPTH - 1);
  localparam logic [OUT_W-1:0] Absent   = '1;

  logic [CLASS_W-1:0] mem [DEPTH];
  logic [DEPTH-1:0]   present_q;
  logic [COUNT_W-1:0] count_q;

  logic [MODE_W-1:0]  mode_q;
  logic [VALUE_W-1:0] va_q, vb_q;
  logic               ina_q, pa_q, pb_q;
  logic [CLASS_W-1:0] rda_q, rdb_q;
  logic [CLASS_W-1:0] lo_q, hi_q;
  logic [AW-1:0]      sc_q, rd_addr_q;
  logic               rd_valid_q, rd_pres_q;

  logic signed [OUT_W-1:0] cls_a_q, cls_b_q;
  logic                    err_q, done_q;

  logic [AW-1:0]           ra;
  logic                    we;
  logic [AW-1:0]           wa;
  logic [CLASS_W-1:0]      wd, swept;
  logic                    eq_ab, add_new, merge_err, need_sweep;
  logic signed [OUT_W-1:0] ca9, cb9, new9;

  assign eq_ab      = (va_q == vb_q);
  assign add_new    = (mode_q == MODE_ADD) && ina_q && !pa_q;
  assign merge_err  = (mode_q == MODE_MERGE) && !eq_ab && !(pa_q && pb_q);
  assign need_sweep = (mode_q == MODE_MERGE) && !eq_ab && pa_q && pb_q && (rda_q != rdb_q);
  assign ca9        = pa_q ? {1'b0, rda_q} : Absent;
  assign cb9        = pb_q ? {1'b0, rdb_q} : Absent;
  assign new9       = {1'b0, count_q[CLASS_W-1:0]};

  assign sts_o.need_sweep = need_sweep;
  assign sts_o.sweep_last = (sc_q == LastAddr);

  assign ra = cmd_i.accept ? value_a_i[AW-1:0] : sc_q;

  always_comb begin
    if (rda_q == hi_q) begin
      swept = lo_q;
    end else if (rda_q > hi_q) begin
      swept = rda_q - CLASS_W'(1);
    end else begin
      swept = rda_q;
    end
  end

  always_comb begin
    if (cmd_i.look && add_new) begin
      we = 1'b1;
      wa = va_q[AW-1:0];
      wd = count_q[CLASS_W-1:0];
    end else begin
      we = rd_valid_q && rd_pres_q;
      wa = rd_addr_q;
      wd = swept;
    end
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[wa] <= wd;
    end
    rda_q <= mem[ra];
    rdb_q <= mem[value_b_i[AW-1:0]];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      present_q <= '0;
      count_q   <= '0;
      done_q    <= 1'b0;
    end else begin
      done_q <= cmd_i.finish;
      if (cmd_i.look && add_new) begin
        present_q[va_q[AW-1:0]] <= 1'b1;
        count_q                 <= count_q + COUNT_W'(1);
      end else if (cmd_i.drain) begin
        count_q <= count_q - COUNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      mode_q <= mode_i;
      va_q   <= value_a_i;
      vb_q   <= value_b_i;
      ina_q  <= ({1'b0, value_a_i} < DepthW);
      pa_q   <= ({1'b0, value_a_i} < DepthW) && present_q[value_a_i[AW-1:0]];
      pb_q   <= ({1'b0, value_b_i} < DepthW) && present_q[value_b_i[AW-1:0]];
    end
    if (cmd_i.look) begin
      lo_q    <= (rda_q < rdb_q) ? rda_q : rdb_q;
      hi_q    <= (rda_q < rdb_q) ? rdb_q : rda_q;
      sc_q    <= '0;
      cls_a_q <= add_new ? new9 : ca9;
      cls_b_q <= (add_new && eq_ab) ? new9 : cb9;
      err_q   <= merge_err;
    end else if (cmd_i.sweep) begin
      sc_q <= sc_q + AW'(1);
    end else if (cmd_i.drain) begin
      cls_a_q <= {1'b0, lo_q};
      cls_b_q <= {1'b0, lo_q};
    end
    rd_addr_q <= sc_q;
    rd_pres_q <= present_q[sc_q];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_valid_q <= 1'b0;
    end else begin
      rd_valid_q <= cmd_i.sweep;
    end
  end

  assign done_o        = done_q;
  assign class_a_o     = cls_a_q;
  assign class_b_o     = cls_b_q;
  assign class_count_o = count_q;
  assign error_o       = err_q;

endmodule
